[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/mie_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned IMM_W   = 16;
    localparam int unsigned SHAMT_W = 5;
    localparam int unsigned CMD_W   = 6;
    localparam int unsigned STAT_W  = 2;

    // Operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 6'd0,  CMD_ADDU  = 6'd1,  CMD_ADDI  = 6'd2,  CMD_ADDIU = 6'd3,
        CMD_SUB   = 6'd4,  CMD_SUBU  = 6'd5,  CMD_AND   = 6'd6,  CMD_ANDI  = 6'd7,
        CMD_OR    = 6'd8,  CMD_ORI   = 6'd9,  CMD_XOR   = 6'd10, CMD_XORI  = 6'd11,
        CMD_NOR   = 6'd12, CMD_LUI   = 6'd13, CMD_SLT   = 6'd14, CMD_SLTU  = 6'd15,
        CMD_SLTI  = 6'd16, CMD_SLTIU = 6'd17, CMD_SLL   = 6'd18, CMD_SRL   = 6'd19,
        CMD_SRA   = 6'd20, CMD_SLLV  = 6'd21, CMD_SRLV  = 6'd22, CMD_SRAV  = 6'd23,
        CMD_MFHI  = 6'd24, CMD_MFLO  = 6'd25, CMD_MTHI  = 6'd26, CMD_MTLO  = 6'd27,
        CMD_BEQ   = 6'd28, CMD_BNE   = 6'd29, CMD_BLEZ  = 6'd30, CMD_BGTZ  = 6'd31,
        CMD_BLTZ  = 6'd32, CMD_BGEZ  = 6'd33, CMD_TGE   = 6'd34, CMD_TGEU  = 6'd35,
        CMD_TLT   = 6'd36, CMD_TLTU  = 6'd37, CMD_TEQ   = 6'd38, CMD_TNE   = 6'd39,
        CMD_TGEI  = 6'd40, CMD_TGEIU = 6'd41, CMD_TLTI  = 6'd42, CMD_TLTIU = 6'd43,
        CMD_TEQI  = 6'd44, CMD_TNEI  = 6'd45
    } cmd_t;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_TRAP     = 2'd2;

    // LUI places the immediate in the upper half
    localparam int unsigned IMM_SHIFT = 16;

    // One accepted input beat
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [WORD_W-1:0]  rs_value;
        logic [WORD_W-1:0]  rt_value;
        logic [IMM_W-1:0]   imm16;
        logic [SHAMT_W-1:0] shift_amount;
    } item_t;

    // Execute outcome, including HI/LO write enables
    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              writes_register;
        logic              branch_taken;
        logic [STAT_W-1:0] status;
        logic              hi_we;
        logic              lo_we;
    } alu_out_t;

endpackage

`default_nettype wire

[sv/mie_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

// Combinational execute logic for one operation.
module mie_alu (
    input  var mie_pkg::item_t              item,
    input  wire logic [mie_pkg::WORD_W-1:0] hi_value,
    input  wire logic [mie_pkg::WORD_W-1:0] lo_value,
    output mie_pkg::alu_out_t               alu_out
);

    logic [mie_pkg::WORD_W-1:0]  rs;
    logic [mie_pkg::WORD_W-1:0]  rt;
    logic [mie_pkg::WORD_W-1:0]  zimm;
    logic [mie_pkg::WORD_W-1:0]  simm;
    logic [mie_pkg::WORD_W-1:0]  op_b;
    logic [mie_pkg::WORD_W-1:0]  add_res;
    logic [mie_pkg::WORD_W-1:0]  sub_res;
    logic [mie_pkg::SHAMT_W-1:0] sh;
    logic                        use_imm;
    logic                        add_ovf;
    logic                        sub_ovf;
    logic                        lt_s;
    logic                        lt_u;
    logic                        eq;
    logic                        rs_neg;
    logic                        rs_zero;
    mie_pkg::cmd_t               cmd;

    assign cmd  = mie_pkg::cmd_t'(item.command);
    assign rs   = item.rs_value;
    assign rt   = item.rt_value;
    assign zimm = {{(mie_pkg::WORD_W-mie_pkg::IMM_W){1'b0}}, item.imm16};
    assign simm = {{(mie_pkg::WORD_W-mie_pkg::IMM_W){item.imm16[mie_pkg::IMM_W-1]}},
                   item.imm16};

    // Second operand: sign-extended immediate or rt
    always_comb
    begin
        use_imm = cmd inside {mie_pkg::CMD_ADDI, mie_pkg::CMD_ADDIU, mie_pkg::CMD_SLTI,
                              mie_pkg::CMD_SLTIU, mie_pkg::CMD_TGEI, mie_pkg::CMD_TGEIU,
                              mie_pkg::CMD_TLTI, mie_pkg::CMD_TLTIU, mie_pkg::CMD_TEQI,
                              mie_pkg::CMD_TNEI};
    end
    assign op_b = use_imm ? simm : rt;

    // Adder, subtractor and compares
    assign add_res = rs + op_b;
    assign sub_res = rs - rt;
    assign add_ovf = (rs[31] ~^ op_b[31]) & (rs[31] ^ add_res[31]);
    assign sub_ovf = (rs[31] ^ rt[31]) & (rs[31] ^ sub_res[31]);
    assign lt_s    = $signed(rs) < $signed(op_b);
    assign lt_u    = rs < op_b;
    assign eq      = rs == op_b;
    assign rs_neg  = rs[mie_pkg::WORD_W-1];
    assign rs_zero = rs == '0;

    // Shift count: shamt field or low bits of rs
    always_comb
    begin
        if (cmd inside {mie_pkg::CMD_SLLV, mie_pkg::CMD_SRLV, mie_pkg::CMD_SRAV})
            sh = rs[mie_pkg::SHAMT_W-1:0];
        else
            sh = item.shift_amount;
    end

    // Operation decode
    always_comb
    begin
        alu_out                 = '0;
        alu_out.writes_register = 1'b1;
        case (cmd)
            mie_pkg::CMD_ADD, mie_pkg::CMD_ADDI:
            begin
                alu_out.result = add_res;
                if (add_ovf)
                    alu_out.status = mie_pkg::STATUS_OVERFLOW;
            end
            mie_pkg::CMD_ADDU, mie_pkg::CMD_ADDIU: alu_out.result = add_res;
            mie_pkg::CMD_SUB:
            begin
                alu_out.result = sub_res;
                if (sub_ovf)
                    alu_out.status = mie_pkg::STATUS_OVERFLOW;
            end
            mie_pkg::CMD_SUBU:  alu_out.result = sub_res;
            mie_pkg::CMD_AND:   alu_out.result = rs & rt;
            mie_pkg::CMD_ANDI:  alu_out.result = rs & zimm;
            mie_pkg::CMD_OR:    alu_out.result = rs | rt;
            mie_pkg::CMD_ORI:   alu_out.result = rs | zimm;
            mie_pkg::CMD_XOR:   alu_out.result = rs ^ rt;
            mie_pkg::CMD_XORI:  alu_out.result = rs ^ zimm;
            mie_pkg::CMD_NOR:   alu_out.result = ~(rs | rt);
            mie_pkg::CMD_LUI:   alu_out.result = zimm << mie_pkg::IMM_SHIFT;
            mie_pkg::CMD_SLT, mie_pkg::CMD_SLTI:
                alu_out.result = {{(mie_pkg::WORD_W-1){1'b0}}, lt_s};
            mie_pkg::CMD_SLTU, mie_pkg::CMD_SLTIU:
                alu_out.result = {{(mie_pkg::WORD_W-1){1'b0}}, lt_u};
            mie_pkg::CMD_SLL, mie_pkg::CMD_SLLV: alu_out.result = rt << sh;
            mie_pkg::CMD_SRL, mie_pkg::CMD_SRLV: alu_out.result = rt >> sh;
            mie_pkg::CMD_SRA, mie_pkg::CMD_SRAV:
                alu_out.result = $unsigned($signed(rt) >>> sh);
            mie_pkg::CMD_MFHI:  alu_out.result = hi_value;
            mie_pkg::CMD_MFLO:  alu_out.result = lo_value;
            mie_pkg::CMD_MTHI:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.hi_we           = 1'b1;
            end
            mie_pkg::CMD_MTLO:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.lo_we           = 1'b1;
            end
            mie_pkg::CMD_BEQ:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.branch_taken    = eq;
            end
            mie_pkg::CMD_BNE:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.branch_taken    = !eq;
            end
            mie_pkg::CMD_BLEZ:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.branch_taken    = rs_neg | rs_zero;
            end
            mie_pkg::CMD_BGTZ:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.branch_taken    = !(rs_neg | rs_zero);
            end
            mie_pkg::CMD_BLTZ:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.branch_taken    = rs_neg;
            end
            mie_pkg::CMD_BGEZ:
            begin
                alu_out.writes_register = 1'b0;
                alu_out.branch_taken    = !rs_neg;
            end
            mie_pkg::CMD_TGE, mie_pkg::CMD_TGEI:
            begin
                alu_out.writes_register = 1'b0;
                if (!lt_s)
                    alu_out.status = mie_pkg::STATUS_TRAP;
            end
            mie_pkg::CMD_TGEU, mie_pkg::CMD_TGEIU:
            begin
                alu_out.writes_register = 1'b0;
                if (!lt_u)
                    alu_out.status = mie_pkg::STATUS_TRAP;
            end
            mie_pkg::CMD_TLT, mie_pkg::CMD_TLTI:
            begin
                alu_out.writes_register = 1'b0;
                if (lt_s)
                    alu_out.status = mie_pkg::STATUS_TRAP;
            end
            mie_pkg::CMD_TLTU, mie_pkg::CMD_TLTIU:
            begin
                alu_out.writes_register = 1'b0;
                if (lt_u)
                    alu_out.status = mie_pkg::STATUS_TRAP;
            end
            mie_pkg::CMD_TEQ, mie_pkg::CMD_TEQI:
            begin
                alu_out.writes_register = 1'b0;
                if (eq)
                    alu_out.status = mie_pkg::STATUS_TRAP;
            end
            mie_pkg::CMD_TNE, mie_pkg::CMD_TNEI:
            begin
                alu_out.writes_register = 1'b0;
                if (!eq)
                    alu_out.status = mie_pkg::STATUS_TRAP;
            end
            default:
            begin
                alu_out.writes_register = 1'b0;
            end
        endcase

        // Exceptions, traps and non-writing ops return a zero result
        if (alu_out.status != mie_pkg::STATUS_OK || !alu_out.writes_register)
        begin
            alu_out.result          = '0;
            alu_out.writes_register = 1'b0;
        end
    end

endmodule

`default_nettype wire

[sv/mips_integer_execute_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake             | Beat payload
// --------+-----------------------+---------------------------------------------------
// in      | in_valid / in_ready   | command, rs_value, rt_value, imm16, shift_amount
// out     | out_valid / out_ready | result, writes_register, branch_taken, status
//
// Two register stages: an input register, then the execute logic, then the result
// register. One beat per cycle while the output is not stalled.
// HI/LO are written when an item moves from the input to the result register, so a
// following MFHI/MFLO sees the new value. Reset clears valid bits and HI/LO to zero.
// A stalled output holds both stages; the input register still fills if it is empty.

`include "assert_macros.svh"

module mips_integer_execute_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [5:0]  command,
    input  wire logic [31:0] rs_value,
    input  wire logic [31:0] rt_value,
    input  wire logic [15:0] imm16,
    input  wire logic [4:0]  shift_amount,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result,
    output logic             writes_register,
    output logic             branch_taken,
    output logic [1:0]       status
);

    mie_pkg::item_t             item_reg;
    logic                       item_valid_reg;
    mie_pkg::alu_out_t          alu_out;
    mie_pkg::alu_out_t          res_reg;
    logic                       res_valid_reg;
    logic [mie_pkg::WORD_W-1:0] hi_reg;
    logic [mie_pkg::WORD_W-1:0] lo_reg;
    logic                       advance;
    logic                       accept;

    // Pipeline flow
    assign advance  = !res_valid_reg || out_ready;
    assign in_ready = !item_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command      <= command;
            item_reg.rs_value     <= rs_value;
            item_reg.rt_value     <= rt_value;
            item_reg.imm16        <= imm16;
            item_reg.shift_amount <= shift_amount;
        end
    end

    mie_alu u_alu (
        .item     (item_reg),
        .hi_value (hi_reg),
        .lo_value (lo_reg),
        .alu_out  (alu_out)
    );

    // Result valid and HI/LO
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid_reg;
            if (item_valid_reg && alu_out.hi_we)
                hi_reg <= item_reg.rs_value;
            if (item_valid_reg && alu_out.lo_we)
                lo_reg <= item_reg.rs_value;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
            res_reg <= alu_out;
    end

    assign out_valid       = res_valid_reg;
    assign result          = res_reg.result;
    assign writes_register = res_reg.writes_register;
    assign branch_taken    = res_reg.branch_taken;
    assign status          = res_reg.status;

    // A faulting or trapping result never writes back and carries zero
    `ASSERT_IMPL(a_fault_no_write, clk, rst_n,
        out_valid && status != mie_pkg::STATUS_OK, !writes_register && result == '0)
    // A taken branch never writes back or faults
    `ASSERT_IMPL(a_branch_clean, clk, rst_n,
        out_valid && branch_taken, !writes_register && status == mie_pkg::STATUS_OK)
    // A full input stage behind a stalled output keeps its item
    `ASSERT_NEXT(a_stage_holds, clk, rst_n,
        item_valid_reg && res_valid_reg && !out_ready, item_valid_reg)

endmodule

`default_nettype wire

[verif/mips_integer_execute_unit_tb.sv]
`timescale 1ns / 1ps

module mips_integer_execute_unit_tb;

    import mie_pkg::*;

    localparam int IDLE_PCT     = 11;
    localparam int STALL_LEN    = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 950;
    localparam int STALL_AT_A   = 300;
    localparam int STALL_AT_B   = 900;

    // codes past the last operation do nothing
    localparam logic [CMD_W-1:0] UNUSED_CMD_FIRST = 6'd46;
    localparam logic [CMD_W-1:0] UNUSED_CMD_LAST  = 6'd63;

    typedef struct {
        logic [WORD_W-1:0] result;
        logic              writes_register;
        logic              branch_taken;
        logic [STAT_W-1:0] status;
    } exec_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    item_t cur_item = '0;

    wire               in_ready;
    wire               out_valid;
    wire [WORD_W-1:0]  result;
    wire               writes_register;
    wire               branch_taken;
    wire [STAT_W-1:0]  status;

    item_t        pending_q[$];
    exec_result_t expected_q[$];

    // architectural HI/LO as seen by the predictor
    logic [WORD_W-1:0] hi_q = '0;
    logic [WORD_W-1:0] lo_q = '0;

    int  beats_sent    = 0;
    int  beats_checked = 0;
    int  err_count     = 0;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    bit  seen_cmd[64];

    mips_integer_execute_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (cur_item.command),
        .rs_value        (cur_item.rs_value),
        .rt_value        (cur_item.rt_value),
        .imm16           (cur_item.imm16),
        .shift_amount    (cur_item.shift_amount),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result          (result),
        .writes_register (writes_register),
        .branch_taken    (branch_taken),
        .status          (status)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic add_ovf(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                     logic [WORD_W-1:0] r);
        return (a[31] == b[31]) && (r[31] != a[31]);
    endfunction

    // Execute one operation against the predictor's HI/LO
    function automatic exec_result_t execute_op(item_t it);
        logic [WORD_W-1:0] rs, rt, zimm, simm, res;
        logic [4:0]        vsa;
        logic              wr, taken, trap;
        logic [STAT_W-1:0] st;
        exec_result_t      r;
        rs    = it.rs_value;
        rt    = it.rt_value;
        zimm  = {16'h0000, it.imm16};
        simm  = {{16{it.imm16[15]}}, it.imm16};
        vsa   = rs[4:0];
        res   = '0;
        wr    = 1'b1;
        taken = 1'b0;
        trap  = 1'b0;
        st    = STATUS_OK;
        case (it.command)
            CMD_ADD:
            begin
                res = rs + rt;
                if (add_ovf(rs, rt, res))
                    st = STATUS_OVERFLOW;
            end
            CMD_ADDU:  res = rs + rt;
            CMD_ADDI:
            begin
                res = rs + simm;
                if (add_ovf(rs, simm, res))
                    st = STATUS_OVERFLOW;
            end
            CMD_ADDIU: res = rs + simm;
            CMD_SUB:
            begin
                res = rs - rt;
                if ((rs[31] != rt[31]) && (res[31] != rs[31]))
                    st = STATUS_OVERFLOW;
            end
            CMD_SUBU:  res = rs - rt;
            CMD_AND:   res = rs & rt;
            CMD_ANDI:  res = rs & zimm;
            CMD_OR:    res = rs | rt;
            CMD_ORI:   res = rs | zimm;
            CMD_XOR:   res = rs ^ rt;
            CMD_XORI:  res = rs ^ zimm;
            CMD_NOR:   res = ~(rs | rt);
            CMD_LUI:   res = zimm << IMM_SHIFT;
            CMD_SLT:   res = {31'd0, $signed(rs) < $signed(rt)};
            CMD_SLTU:  res = {31'd0, rs < rt};
            CMD_SLTI:  res = {31'd0, $signed(rs) < $signed(simm)};
            CMD_SLTIU: res = {31'd0, rs < simm};
            CMD_SLL:   res = rt << it.shift_amount;
            CMD_SRL:   res = rt >> it.shift_amount;
            CMD_SRA:   res = $signed(rt) >>> it.shift_amount;
            CMD_SLLV:  res = rt << vsa;
            CMD_SRLV:  res = rt >> vsa;
            CMD_SRAV:  res = $signed(rt) >>> vsa;
            CMD_MFHI:  res = hi_q;
            CMD_MFLO:  res = lo_q;
            CMD_MTHI:
            begin
                hi_q = rs;
                wr   = 1'b0;
            end
            CMD_MTLO:
            begin
                lo_q = rs;
                wr   = 1'b0;
            end
            CMD_BEQ:   begin taken = (rs == rt);                 wr = 1'b0; end
            CMD_BNE:   begin taken = (rs != rt);                 wr = 1'b0; end
            CMD_BLEZ:  begin taken = rs[31] || (rs == '0);       wr = 1'b0; end
            CMD_BGTZ:  begin taken = !rs[31] && (rs != '0);      wr = 1'b0; end
            CMD_BLTZ:  begin taken = rs[31];                     wr = 1'b0; end
            CMD_BGEZ:  begin taken = !rs[31];                    wr = 1'b0; end
            CMD_TGE:   begin trap = $signed(rs) >= $signed(rt);  wr = 1'b0; end
            CMD_TGEU:  begin trap = rs >= rt;                    wr = 1'b0; end
            CMD_TLT:   begin trap = $signed(rs) < $signed(rt);   wr = 1'b0; end
            CMD_TLTU:  begin trap = rs < rt;                     wr = 1'b0; end
            CMD_TEQ:   begin trap = rs == rt;                    wr = 1'b0; end
            CMD_TNE:   begin trap = rs != rt;                    wr = 1'b0; end
            CMD_TGEI:  begin trap = $signed(rs) >= $signed(simm); wr = 1'b0; end
            CMD_TGEIU: begin trap = rs >= simm;                  wr = 1'b0; end
            CMD_TLTI:  begin trap = $signed(rs) < $signed(simm); wr = 1'b0; end
            CMD_TLTIU: begin trap = rs < simm;                   wr = 1'b0; end
            CMD_TEQI:  begin trap = rs == simm;                  wr = 1'b0; end
            CMD_TNEI:  begin trap = rs != simm;                  wr = 1'b0; end
            default:   wr = 1'b0;
        endcase
        if (trap)
            st = STATUS_TRAP;
        // exceptions, traps and non-writing ops return a zero result
        if (st != STATUS_OK || !wr)
        begin
            res = '0;
            wr  = 1'b0;
        end
        r.result          = res;
        r.writes_register = wr;
        r.branch_taken    = taken;
        r.status          = st;
        return r;
    endfunction

    // Input side: offer queued beats, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin : beat_driver
        item_t nxt;
        logic  quiet;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(execute_op(cur_item));
                seen_cmd[cur_item.command] = 1'b1;
                beats_sent++;
            end
            if (!in_valid || in_ready)
            begin
                quiet = (beats_sent >= QUIET_FIRST) && (beats_sent < QUIET_LAST);
                if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_q.pop_front();
                    cur_item <= nxt;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare each beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_check
        exec_result_t want;
        logic         quiet;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result beat, result %h", $time, result);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result !== want.result)
                    begin
                        err_count++;
                        $display("%0t: result exp %h got %h", $time, want.result, result);
                    end
                    if (writes_register !== want.writes_register)
                    begin
                        err_count++;
                        $display("%0t: writes_register exp %b got %b", $time,
                                 want.writes_register, writes_register);
                    end
                    if (branch_taken !== want.branch_taken)
                    begin
                        err_count++;
                        $display("%0t: branch_taken exp %b got %b", $time,
                                 want.branch_taken, branch_taken);
                    end
                    if (status !== want.status)
                    begin
                        err_count++;
                        $display("%0t: status exp %0d got %0d", $time, want.status, status);
                    end
                end
                beats_checked++;
                // long back-pressure so the pipeline fills and stalls its input
                if (beats_checked == STALL_AT_A || beats_checked == STALL_AT_B)
                    stall_left = STALL_LEN;
            end
            quiet = (beats_checked >= QUIET_FIRST) && (beats_checked < QUIET_LAST);
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_op(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] rs,
                           logic [WORD_W-1:0] rt, logic [IMM_W-1:0] imm,
                           logic [SHAMT_W-1:0] sa);
        item_t it;
        it.command      = cmd;
        it.rs_value     = rs;
        it.rt_value     = rt;
        it.imm16        = imm;
        it.shift_amount = sa;
        pending_q.push_back(it);
    endtask

    // Operand values weighted toward the sign and carry corners
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IMM_W-1:0] pick_imm();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic add_random_items(int count);
        int                 n;
        logic [CMD_W-1:0]   cmd;
        logic [WORD_W-1:0]  rs, rt, simm;
        logic [IMM_W-1:0]   imm;
        n = 0;
        while (n < count)
        begin
            rs  = pick_word();
            rt  = pick_word();
            imm = pick_imm();
            // HI/LO write followed by a read of HI or LO
            if ($urandom_range(99) < 10)
            begin
                push_op($urandom_range(1) ? CMD_MTHI : CMD_MTLO, rs, rt, imm,
                        5'($urandom_range(31)));
                push_op($urandom_range(1) ? CMD_MFHI : CMD_MFLO, pick_word(),
                        pick_word(), pick_imm(), 5'($urandom_range(31)));
                n += 2;
            end
            else
            begin
                if ($urandom_range(99) < 5)
                    cmd = 6'($urandom_range(UNUSED_CMD_LAST, UNUSED_CMD_FIRST));
                else
                    cmd = 6'($urandom_range(int'(CMD_TNEI), int'(CMD_ADD)));
                simm = {{16{imm[15]}}, imm};
                // equal and neighboring operands for compares, branches and traps
                case ($urandom_range(5))
                    0:       rt = rs;
                    1:       rs = simm;
                    2:       rt = rs + 1;
                    3:       rs = simm - 1;
                    default: ;
                endcase
                push_op(cmd, rs, rt, imm, 5'($urandom_range(31)));
                n++;
            end
        end
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    endtask

    initial
    begin : stimulus
        int codes_seen;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        push_op(CMD_MFHI,  32'h1234_5678, 32'h0,          16'h0,    5'd0);
        push_op(CMD_MFLO,  32'h0,          32'h1,          16'h0,    5'd0);
        push_op(CMD_ADD,   32'h7FFF_FFFF, 32'h0000_0001, 16'h0,    5'd0);
        push_op(CMD_ADD,   32'h8000_0000, 32'hFFFF_FFFF, 16'h0,    5'd0);
        push_op(CMD_ADDI,  32'h7FFF_FFFF, 32'h0,          16'h0001, 5'd0);
        push_op(CMD_ADDI,  32'h8000_0000, 32'h0,          16'hFFFF, 5'd0);
        push_op(CMD_SUB,   32'h8000_0000, 32'h0000_0001, 16'h0,    5'd0);
        push_op(CMD_ADDU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,    5'd0);
        push_op(CMD_SLTIU, 32'hFFFF_FFFE, 32'h0,          16'hFFFF, 5'd0);
        push_op(CMD_TGEIU, 32'h8000_0000, 32'h0,          16'h8000, 5'd0);
        push_op(CMD_TLTIU, 32'h0000_7FFF, 32'h0,          16'hFFFF, 5'd0);
        push_op(CMD_SLLV,  32'hFFFF_FFE3, 32'hFFFF_FFFF, 16'h0,    5'd0);
        push_op(CMD_SRAV,  32'hFFFF_FFFF, 32'h8000_0000, 16'h0,    5'd0);
        push_op(CMD_SRA,   32'h0,          32'h8000_0000, 16'h0,    5'd31);
        push_op(CMD_MTHI,  32'hDEAD_BEEF, 32'h0,          16'h0,    5'd0);
        push_op(CMD_MFHI,  32'h0,          32'h0,          16'h0,    5'd0);
        push_op(CMD_MTLO,  32'hFFFF_FFFF, 32'h0,          16'h0,    5'd0);
        push_op(CMD_MFLO,  32'h0,          32'h0,          16'h0,    5'd0);
        push_op(CMD_BEQ,   32'hA5A5_A5A5, 32'hA5A5_A5A5, 16'h0,    5'd0);
        push_op(CMD_BLEZ,  32'h0,          32'h0,          16'h0,    5'd0);
        push_op(CMD_BGTZ,  32'h8000_0000, 32'h0,          16'h0,    5'd0);
        push_op(CMD_TEQ,   32'h0000_0005, 32'h0000_0005, 16'h0,    5'd0);
        push_op(CMD_TNEI,  32'hFFFF_8000, 32'h0,          16'h8000, 5'd0);
        push_op(CMD_LUI,   32'h0,          32'h0,          16'hFFFF, 5'd0);
        push_op(UNUSED_CMD_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
        wait_for_drain();

        add_random_items(600);
        // sender holds off until the pipeline is empty
        wait_for_drain();
        add_random_items(650);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        codes_seen = 0;
        foreach (seen_cmd[i])
            codes_seen += seen_cmd[i];
        $display("Checked %0d result beats from %0d input beats, %0d of 64 command codes,",
                 beats_checked, beats_sent, codes_seen);
        $display("with overflow, trap, HI/LO and unused codes, long back-pressure, drains.");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
